FILE: sv/htm_pkg.sv
// ----------------------------------------------------------------------------
// htm_pkg
// Shared types and constants for the helix turn marker.
// ----------------------------------------------------------------------------
`default_nettype none

package htm_pkg;

    // turn lengths, in residues
    localparam int SHORT_TURN = 3;
    localparam int LONG_TURN  = 4;

    // default width of the residue index
    localparam int INDEX_BITS_DEF = 16;

    // width of the segment index result fields
    localparam int SEG_W = 16;

    // minimum helix length register
    localparam int          MINLEN_W   = 8;
    localparam logic [7:0]  MINLEN_RST = 8'd3;

    // APB port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_MIN_HELIX_LENGTH = 1'b0;

    // marks of one residue for one turn length
    typedef struct packed {
        logic start;
        logic inner;
        logic stop;
        logic helix;
    } t_marks;

endpackage

`default_nettype wire

FILE: sv/htm_turn.sv
// ----------------------------------------------------------------------------
// htm_turn
// Acceptor history and turn/helix marks for one turn length.
// ----------------------------------------------------------------------------
`default_nettype none

module htm_turn #(
    parameter int N = htm_pkg::SHORT_TURN
) (
    input  wire logic [N-1:0]         i_hist,
    input  wire logic                 i_cur,
    output htm_pkg::t_marks           o_marks,
    output logic [N-1:0]              o_hist_next
);

    // bit 0 is this residue, bit m is the residue m places back
    logic [N:0] w;

    assign w = {i_hist, i_cur};

    assign o_marks.start = w[0];
    assign o_marks.inner = |w[N-1:1];
    assign o_marks.stop  = w[N];
    // two consecutive acceptors among this residue and the N before it
    assign o_marks.helix = |(w[N-1:0] & w[N:1]);

    assign o_hist_next = w[N-1:0];

endmodule

`default_nettype wire

FILE: sv/helix_turn_marker_core.sv
// ----------------------------------------------------------------------------
// helix_turn_marker_core
// Per-residue three/four-turn marks, helix marks and closed helix segments.
// ----------------------------------------------------------------------------
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-------------------------------------------
//  residue  | i_valid  | o_stall  | i_bond_ahead_three/four, i_is_last
//  result   | o_valid  | i_stall  | o_*_turn_*, o_*_helix_mark, o_segment_*
//  config   | psel/penable/pwrite (pready tied high) | paddr, pwdata, prdata
//
// One residue per cycle while o_stall is low; each taken residue is
// registered into the single result register in the cycle after it is taken.
// A new residue is taken while the result register is empty or drained in
// the same cycle, so o_stall follows i_stall only while a result is held.
// Reset clears histories, index, run state and sets min_helix_length to 3.
// A residue with i_is_last set clears all residue state after its result.
// ----------------------------------------------------------------------------
`default_nettype none

module helix_turn_marker_core #(
    parameter int INDEX_BITS = htm_pkg::INDEX_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_bond_ahead_three,
    input  wire logic                          i_bond_ahead_four,
    input  wire logic                          i_is_last,

    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_short_turn_start,
    output logic                               o_short_turn_inner,
    output logic                               o_short_turn_end,
    output logic                               o_long_turn_start,
    output logic                               o_long_turn_inner,
    output logic                               o_long_turn_end,
    output logic                               o_short_helix_mark,
    output logic                               o_long_helix_mark,
    output logic                               o_segment_valid,
    output logic [htm_pkg::SEG_W-1:0]          o_segment_first,
    output logic [htm_pkg::SEG_W-1:0]          o_segment_final,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [htm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [htm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [htm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int SN    = htm_pkg::SHORT_TURN;
    localparam int LN    = htm_pkg::LONG_TURN;
    localparam int LEN_W = (INDEX_BITS > htm_pkg::MINLEN_W) ? INDEX_BITS
                                                            : htm_pkg::MINLEN_W;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

    // configuration
    logic [htm_pkg::MINLEN_W-1:0] r_min_len;
    logic                         cfg_wr;
    logic                         cfg_hit;

    // residue state
    logic [SN-1:0]         r_short_hist, n_short_hist;
    logic [LN-1:0]         r_long_hist,  n_long_hist;
    logic [INDEX_BITS-1:0] r_index,      n_index;
    logic                  r_run_active, n_run_active;
    logic [INDEX_BITS-1:0] r_run_begin,  n_run_begin;

    // result register
    logic                       r_out_valid;
    htm_pkg::t_marks            r_short_marks, r_long_marks;
    logic                       r_seg_valid;
    logic [htm_pkg::SEG_W-1:0]  r_seg_first, r_seg_final;

    htm_pkg::t_marks       short_marks, long_marks;
    logic [SN-1:0]         short_hist_next;
    logic [LN-1:0]         long_hist_next;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  helix_any;
    logic [INDEX_BITS-1:0] run_len;
    logic                  seg_close;
    logic [INDEX_BITS-1:0] seg_final;

    // ---- configuration port ----
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == htm_pkg::REG_MIN_HELIX_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? htm_pkg::APB_DATA_W'(r_min_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= htm_pkg::MINLEN_RST;
        end else if (cfg_wr) begin
            r_min_len <= pwdata[htm_pkg::MINLEN_W-1:0];
        end
    end

    // ---- handshake ----
    assign o_stall  = r_out_valid && i_stall;
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;

    // ---- turn marks ----
    htm_turn #(.N(SN)) u_short (
        .i_hist      (r_short_hist),
        .i_cur       (i_bond_ahead_three),
        .o_marks     (short_marks),
        .o_hist_next (short_hist_next)
    );

    htm_turn #(.N(LN)) u_long (
        .i_hist      (r_long_hist),
        .i_cur       (i_bond_ahead_four),
        .o_marks     (long_marks),
        .o_hist_next (long_hist_next)
    );

    // ---- helix runs ----
    assign helix_any = short_marks.helix || long_marks.helix;
    assign run_len   = r_index - r_run_begin;
    assign seg_close = !helix_any && r_run_active
                       && (LEN_W'(run_len) >= LEN_W'(r_min_len));
    assign seg_final = (r_index > r_run_begin) ? r_index - 1'b1 : r_run_begin;

    always_comb begin
        n_short_hist = short_hist_next;
        n_long_hist  = long_hist_next;
        n_index      = (r_index < INDEX_MAX) ? r_index + 1'b1 : r_index;
        n_run_active = helix_any;
        n_run_begin  = (helix_any && !r_run_active) ? r_index : r_run_begin;
        // last residue of the chain: drop everything, open run included
        if (i_is_last) begin
            n_short_hist = '0;
            n_long_hist  = '0;
            n_index      = '0;
            n_run_active = 1'b0;
            n_run_begin  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_hist <= '0;
            r_long_hist  <= '0;
            r_index      <= '0;
            r_run_active <= 1'b0;
            r_run_begin  <= '0;
        end else if (in_xfer) begin
            r_short_hist <= n_short_hist;
            r_long_hist  <= n_long_hist;
            r_index      <= n_index;
            r_run_active <= n_run_active;
            r_run_begin  <= n_run_begin;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_short_marks <= short_marks;
            r_long_marks  <= long_marks;
            r_seg_valid   <= seg_close;
            r_seg_first   <= seg_close ? htm_pkg::SEG_W'(r_run_begin) : '0;
            r_seg_final   <= seg_close ? htm_pkg::SEG_W'(seg_final) : '0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_short_turn_start = r_short_marks.start;
    assign o_short_turn_inner = r_short_marks.inner;
    assign o_short_turn_end   = r_short_marks.stop;
    assign o_long_turn_start  = r_long_marks.start;
    assign o_long_turn_inner  = r_long_marks.inner;
    assign o_long_turn_end    = r_long_marks.stop;
    assign o_short_helix_mark = r_short_marks.helix;
    assign o_long_helix_mark  = r_long_marks.helix;
    assign o_segment_valid    = r_seg_valid;
    assign o_segment_first    = r_seg_first;
    assign o_segment_final    = r_seg_final;

    // ---- assertions ----
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_active |-> (r_run_begin <= r_index))
        else $error("open run begins after current index");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_is_last) |=> (!r_run_active && r_index == '0
                                    && r_short_hist == '0 && r_long_hist == '0))
        else $error("residue state not cleared after last residue");

    a_seg_no_helix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_segment_valid) |-> (!o_short_helix_mark && !o_long_helix_mark))
        else $error("segment reported on a helix-marked residue");

    a_seg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_segment_valid) |-> (o_segment_first == '0
                                           && o_segment_final == '0))
        else $error("segment indices nonzero without a segment");

endmodule

`default_nettype wire
